@@ design/skt_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skt_pkg
// Shared types and constants for the sorted key table.
// ---------------------------------------------------------------------------
package skt_pkg;

    localparam int DEF_CAPACITY = 128;
    localparam int GRP_SIZE     = 16;
    localparam int KEY_W        = 32;
    localparam int PAY_W        = 64;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 8;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
        logic                    cmp;
        logic                    ins;
        logic                    rem;
    } bcast_t;

endpackage

@@ design/skt_cell.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skt_cell
// One slot of the table: holds a key and payload, compares against the
// broadcast key and shifts with its neighbors on insert or remove.
// ---------------------------------------------------------------------------
module skt_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  skt_pkg::bcast_t                     bc,
    input  logic                                occ,
    input  logic                                lt_left,
    input  logic signed [skt_pkg::KEY_W-1:0]    key_left,
    input  logic [skt_pkg::PAY_W-1:0]           pay_left,
    input  logic signed [skt_pkg::KEY_W-1:0]    key_right,
    input  logic [skt_pkg::PAY_W-1:0]           pay_right,
    output logic signed [skt_pkg::KEY_W-1:0]    key_q,
    output logic [skt_pkg::PAY_W-1:0]           pay_q,
    output logic                                lt_q,
    output logic                                eq_q
);

    logic signed [skt_pkg::KEY_W-1:0] key_reg;
    logic [skt_pkg::PAY_W-1:0]        pay_reg;
    logic                             lt_reg;
    logic                             eq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (bc.cmp)
        begin
            lt_reg <= occ && (key_reg < bc.key);
            eq_reg <= occ && (key_reg == bc.key);
        end
    end

    always_ff @(posedge clk)
    begin
        if (bc.ins && !lt_reg)
        begin
            if (lt_left)
            begin
                key_reg <= bc.key;
                pay_reg <= bc.payload;
            end
            else
            begin
                key_reg <= key_left;
                pay_reg <= pay_left;
            end
        end
        else if (bc.rem && !lt_reg)
        begin
            key_reg <= key_right;
            pay_reg <= pay_right;
        end
    end

    assign key_q = key_reg;
    assign pay_q = pay_reg;
    assign lt_q  = lt_reg;
    assign eq_q  = eq_reg;

endmodule

@@ design/skt_group.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skt_group
// Registered match reduction over one group of cells: hit flag and the
// payload of the matching cell.
// ---------------------------------------------------------------------------
module skt_group #(
    parameter int N = skt_pkg::GRP_SIZE
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [N-1:0]                  eq,
    input  logic [skt_pkg::PAY_W-1:0]     pay [N],
    output logic                          hit_q,
    output logic [skt_pkg::PAY_W-1:0]     pay_q
);

    logic                      hit_reg;
    logic [skt_pkg::PAY_W-1:0] pay_reg;
    logic [skt_pkg::PAY_W-1:0] pay_or;

    always_comb
    begin
        pay_or = '0;
        for (int j = 0; j < N; j++)
        begin
            pay_or = pay_or | (pay[j] & {skt_pkg::PAY_W{eq[j]}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (en)
        begin
            hit_reg <= |eq;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg <= pay_or;
        end
    end

    assign hit_q = hit_reg;
    assign pay_q = pay_reg;

endmodule

@@ design/sorted_key_table.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_key_table
// Table of unique signed keys with 64-bit payloads, kept in ascending order.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_stall): req_type, key, payload_in.
//   Result channel (out_valid/out_stall): status, payload_out, entry_count.
//   An item is taken when valid is high and stall is low.
// Timing:
//   Each request passes through these steps: accept, compare in every cell,
//   match reduction per group of cells, then final reduction with the shift.
//   The result is valid the cycle after the shift step; a new request is
//   taken only once the table is back in idle after that step, so no new
//   item is taken while one is in flight. The group reduction sets the step count.
//   An insert or remove moves every affected cell by one slot at once.
// Reset:
//   The internal entry count clears to zero; the entry_count output register,
//   stored keys and payloads are not reset.
// Stall:
//   A stalled result holds in its output register; the next request is
//   still accepted and stops at the shift step until the result is taken.
module sorted_key_table #(
    parameter int CAPACITY = skt_pkg::DEF_CAPACITY
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [skt_pkg::OP_W-1:0]             req_type,
    input  logic signed [skt_pkg::KEY_W-1:0]     key,
    input  logic [skt_pkg::PAY_W-1:0]            payload_in,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [skt_pkg::STATUS_W-1:0]         status,
    output logic [skt_pkg::PAY_W-1:0]            payload_out,
    output logic [skt_pkg::COUNT_W-1:0]          entry_count
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int G    = skt_pkg::GRP_SIZE;
    localparam int NGRP = (CAPACITY + G - 1) / G;
    localparam int PADN = NGRP * G;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_GRP  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]                        count_reg, count_next;
    logic [skt_pkg::OP_W-1:0]             op_reg;
    logic signed [skt_pkg::KEY_W-1:0]     key_reg;
    logic [skt_pkg::PAY_W-1:0]            pay_reg;

    logic                                 out_valid_reg, out_valid_next;
    logic [skt_pkg::STATUS_W-1:0]         status_reg, status_next;
    logic [skt_pkg::PAY_W-1:0]            pout_reg, pout_next;
    logic [skt_pkg::COUNT_W-1:0]          ecount_reg, ecount_next;

    skt_pkg::bcast_t                      bc;
    logic                                 accept;
    logic                                 out_free;
    logic                                 do_ins, do_rem;

    logic [CAPACITY-1:0]                  occ;
    logic signed [skt_pkg::KEY_W-1:0]     cell_key [CAPACITY];
    logic [skt_pkg::PAY_W-1:0]            cell_pay [CAPACITY];
    logic [CAPACITY-1:0]                  cell_lt;
    logic [CAPACITY-1:0]                  cell_eq;

    logic [PADN-1:0]                      eq_pad;
    logic [skt_pkg::PAY_W-1:0]            pay_pad [PADN];
    logic [NGRP-1:0]                      grp_hit;
    logic [skt_pkg::PAY_W-1:0]            grp_pay [NGRP];
    logic                                 hit;
    logic [skt_pkg::PAY_W-1:0]            hit_pay;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req_type;
            key_reg <= key;
            pay_reg <= payload_in;
        end
    end

    always_comb
    begin
        hit     = |grp_hit;
        hit_pay = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            hit_pay = hit_pay | grp_pay[g];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        pout_next      = pout_reg;
        ecount_next    = ecount_reg;
        do_ins         = 1'b0;
        do_rem         = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_GRP;
            end
            S_GRP:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = skt_pkg::ST_OK;
                    pout_next      = '0;
                    case (op_reg)
                        skt_pkg::OP_INSERT:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                status_next = skt_pkg::ST_FULL;
                            end
                            else if (hit)
                            begin
                                status_next = skt_pkg::ST_DUP;
                            end
                            else
                            begin
                                do_ins     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        skt_pkg::OP_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = skt_pkg::ST_EMPTY;
                            end
                            else if (!hit)
                            begin
                                status_next = skt_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                do_rem     = 1'b1;
                                count_next = count_reg - CW'(1);
                            end
                        end
                        skt_pkg::OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = skt_pkg::ST_EMPTY;
                            end
                            else if (!hit)
                            begin
                                status_next = skt_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                pout_next = hit_pay;
                            end
                        end
                        default:
                        begin
                            status_next = skt_pkg::ST_OK;
                        end
                    endcase
                    ecount_next = skt_pkg::COUNT_W'(32'(count_next));
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        pout_reg   <= pout_next;
        ecount_reg <= ecount_next;
    end

    assign bc.key     = key_reg;
    assign bc.payload = pay_reg;
    assign bc.cmp     = (state_reg == S_CMP);
    assign bc.ins     = do_ins;
    assign bc.rem     = do_rem;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic                             lt_l;
            logic signed [skt_pkg::KEY_W-1:0] key_l, key_r;
            logic [skt_pkg::PAY_W-1:0]        pay_l, pay_r;

            assign occ[i] = (CW'(i) < count_reg);

            if (i == 0)
            begin : g_first
                assign lt_l  = 1'b1;
                assign key_l = key_reg;
                assign pay_l = pay_reg;
            end
            else
            begin : g_mid
                assign lt_l  = cell_lt[i-1];
                assign key_l = cell_key[i-1];
                assign pay_l = cell_pay[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign key_r = cell_key[i];
                assign pay_r = cell_pay[i];
            end
            else
            begin : g_inner
                assign key_r = cell_key[i+1];
                assign pay_r = cell_pay[i+1];
            end

            skt_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .bc        (bc),
                .occ       (occ[i]),
                .lt_left   (lt_l),
                .key_left  (key_l),
                .pay_left  (pay_l),
                .key_right (key_r),
                .pay_right (pay_r),
                .key_q     (cell_key[i]),
                .pay_q     (cell_pay[i]),
                .lt_q      (cell_lt[i]),
                .eq_q      (cell_eq[i])
            );
        end

        for (i = 0; i < PADN; i++)
        begin : g_pad
            if (i < CAPACITY)
            begin : g_real
                assign eq_pad[i]  = cell_eq[i];
                assign pay_pad[i] = cell_pay[i];
            end
            else
            begin : g_fill
                assign eq_pad[i]  = 1'b0;
                assign pay_pad[i] = '0;
            end
        end

        for (i = 0; i < NGRP; i++)
        begin : g_grp
            logic [skt_pkg::PAY_W-1:0] gpay [G];

            for (genvar j = 0; j < G; j++)
            begin : g_sel
                assign gpay[j] = pay_pad[i*G + j];
            end

            skt_group #(.N(G)) u_group (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (state_reg == S_GRP),
                .eq    (eq_pad[i*G +: G]),
                .pay   (gpay),
                .hit_q (grp_hit[i]),
                .pay_q (grp_pay[i])
            );
        end
    endgenerate

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign payload_out = pout_reg;
    assign entry_count = ecount_reg;

endmodule

@@ design/skt_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// skt_checker
// Port-level checks on the sorted key table result channel.
// ---------------------------------------------------------------------------
module skt_checker #(
    parameter int CAPACITY = skt_pkg::DEF_CAPACITY
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [skt_pkg::STATUS_W-1:0]   status,
    input logic [skt_pkg::PAY_W-1:0]      payload_out,
    input logic [skt_pkg::COUNT_W-1:0]    entry_count
);

    localparam logic [skt_pkg::COUNT_W-1:0] CAP_CNT = skt_pkg::COUNT_W'(CAPACITY);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(payload_out) && $stable(entry_count))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == skt_pkg::ST_OK) || (status == skt_pkg::ST_FULL)
            || (status == skt_pkg::ST_DUP) || (status == skt_pkg::ST_EMPTY)
            || (status == skt_pkg::ST_NOT_FOUND))
        else $error("bad status code");

    a_pay_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != skt_pkg::ST_OK) |-> (payload_out == '0))
        else $error("payload on failed request");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == skt_pkg::ST_FULL) |-> (entry_count == CAP_CNT))
        else $error("full status with wrong count");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == skt_pkg::ST_EMPTY) |-> (entry_count == '0))
        else $error("empty status with nonzero count");

endmodule

bind sorted_key_table skt_checker #(.CAPACITY(CAPACITY)) u_skt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .payload_out (payload_out),
    .entry_count (entry_count)
);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted key table.
// A shadow copy of the table predicts status, payload and count for every
// accepted request. Tests cover edge cases with few entries, filling to
// capacity and draining, a long result hold-off, and random traffic.
// Sender bursts and receiver stalls are randomized, apart from the long hold-off.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int CAP       = skt_pkg::DEF_CAPACITY;
    localparam int LONG_HOLD = 200;
    localparam logic [skt_pkg::OP_W-1:0] OP_IGNORED = 2'd3;

    typedef struct packed {
        logic [skt_pkg::STATUS_W-1:0] status;
        logic [skt_pkg::PAY_W-1:0]    payload;
        logic [skt_pkg::COUNT_W-1:0]  count;
    } reply_t;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic [skt_pkg::OP_W-1:0]         req_type;
    logic signed [skt_pkg::KEY_W-1:0] key;
    logic [skt_pkg::PAY_W-1:0]        payload_in;
    logic                             out_valid;
    logic                             out_stall;
    logic [skt_pkg::STATUS_W-1:0]     status;
    logic [skt_pkg::PAY_W-1:0]        payload_out;
    logic [skt_pkg::COUNT_W-1:0]      entry_count;

    logic signed [skt_pkg::KEY_W-1:0] shadow_keys [CAP];
    logic [skt_pkg::PAY_W-1:0]        shadow_pay [CAP];
    int                               shadow_count;
    reply_t                           reply_q [$];
    int                               err_count;
    int                               burst_left;
    bit                               steady;
    bit                               hold_req;

    sorted_key_table #(.CAPACITY(CAP)) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .key         (key),
        .payload_in  (payload_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .payload_out (payload_out),
        .entry_count (entry_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $time, what);
        err_count++;
    endtask

    function automatic reply_t table_apply(input logic [skt_pkg::OP_W-1:0] op,
                                           input logic signed [skt_pkg::KEY_W-1:0] k,
                                           input logic [skt_pkg::PAY_W-1:0] pay);
        reply_t r;
        int     pos;
        bit     hit;
        r.status  = skt_pkg::ST_OK;
        r.payload = '0;
        pos = 0;
        while (pos < shadow_count && shadow_keys[pos] < k)
            pos++;
        hit = (pos < shadow_count) && (shadow_keys[pos] == k);
        case (op)
            skt_pkg::OP_INSERT:
            begin
                if (shadow_count >= CAP)
                    r.status = skt_pkg::ST_FULL;
                else if (hit)
                    r.status = skt_pkg::ST_DUP;
                else
                begin
                    for (int i = shadow_count; i > pos; i--)
                    begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_pay[i]  = shadow_pay[i-1];
                    end
                    shadow_keys[pos] = k;
                    shadow_pay[pos]  = pay;
                    shadow_count++;
                end
            end
            skt_pkg::OP_REMOVE:
            begin
                if (shadow_count == 0)
                    r.status = skt_pkg::ST_EMPTY;
                else if (!hit)
                    r.status = skt_pkg::ST_NOT_FOUND;
                else
                begin
                    for (int i = pos; i + 1 < shadow_count; i++)
                    begin
                        shadow_keys[i] = shadow_keys[i+1];
                        shadow_pay[i]  = shadow_pay[i+1];
                    end
                    shadow_count--;
                end
            end
            skt_pkg::OP_SEARCH:
            begin
                if (shadow_count == 0)
                    r.status = skt_pkg::ST_EMPTY;
                else if (!hit)
                    r.status = skt_pkg::ST_NOT_FOUND;
                else
                    r.payload = shadow_pay[pos];
            end
            default: ;
        endcase
        r.count = shadow_count[skt_pkg::COUNT_W-1:0];
        return r;
    endfunction

    // entered at a rising edge; returns at the edge that takes the item, or after an idle gap when a burst ends
    task automatic send_req(input logic [skt_pkg::OP_W-1:0] op,
                            input logic signed [skt_pkg::KEY_W-1:0] k,
                            input logic [skt_pkg::PAY_W-1:0] pay);
        bit stalled;
        req_type   <= op;
        key        <= k;
        payload_in <= pay;
        in_valid   <= 1'b1;
        forever
        begin
            @(negedge clk);
            stalled = in_stall;
            if (!stalled)
                reply_q.push_back(table_apply(op, k, pay));
            @(posedge clk);
            if (!stalled)
                break;
        end
        if (burst_left > 0)
            burst_left--;
        if (!steady && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 24);
        end
    endtask

    function automatic logic signed [skt_pkg::KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40 && shadow_count > 0)
            return shadow_keys[$urandom_range(0, shadow_count - 1)];
        if (r < 70)
            return $signed($urandom_range(0, 255)) - 128;
        if (r < 90)
            return $urandom;
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0001;
            3: return 32'h7FFF_FFFE;
            4: return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
        endcase
    endfunction

    function automatic logic [skt_pkg::PAY_W-1:0] pick_payload();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [skt_pkg::OP_W-1:0] pick_op(input bit growing);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return OP_IGNORED;
        if (growing)
            return (r < 65) ? skt_pkg::OP_INSERT
                 : (r < 82) ? skt_pkg::OP_SEARCH : skt_pkg::OP_REMOVE;
        return (r < 25) ? skt_pkg::OP_INSERT
             : (r < 45) ? skt_pkg::OP_SEARCH : skt_pkg::OP_REMOVE;
    endfunction

    task automatic test_directed();
        send_req(skt_pkg::OP_SEARCH, 32'h8000_0000, '1);
        send_req(skt_pkg::OP_REMOVE, 32'h7FFF_FFFF, '0);
        send_req(OP_IGNORED,         32'h1234_5678, 64'hDEAD_BEEF_0BAD_F00D);
        send_req(skt_pkg::OP_INSERT, 32'h8000_0000, '1);
        send_req(skt_pkg::OP_INSERT, 32'h7FFF_FFFF, '0);
        send_req(skt_pkg::OP_INSERT, 32'h0000_0000, 64'hA5A5_5A5A_F0F0_0F0F);
        send_req(skt_pkg::OP_INSERT, 32'hFFFF_FFFF, 64'h8000_0000_0000_0001);
        send_req(skt_pkg::OP_INSERT, 32'h0000_0001, 64'h0123_4567_89AB_CDEF);
        send_req(skt_pkg::OP_INSERT, 32'h7FFF_FFFF, 64'h1111_2222_3333_4444);
        send_req(skt_pkg::OP_INSERT, 32'h8000_0000, 64'h5555_6666_7777_8888);
        send_req(skt_pkg::OP_SEARCH, 32'h8000_0000, '0);
        send_req(skt_pkg::OP_SEARCH, 32'h7FFF_FFFF, '1);
        send_req(skt_pkg::OP_SEARCH, 32'hFFFF_FFFF, '0);
        send_req(skt_pkg::OP_SEARCH, 32'h0000_0002, '0);
        send_req(skt_pkg::OP_REMOVE, 32'h8000_0001, '0);
        send_req(OP_IGNORED,         32'hFFFF_FFFF, '1);
        send_req(skt_pkg::OP_REMOVE, 32'h0000_0000, '0);
        send_req(skt_pkg::OP_SEARCH, 32'h0000_0000, '0);
        send_req(skt_pkg::OP_SEARCH, 32'h0000_0001, '0);
        send_req(skt_pkg::OP_REMOVE, 32'h8000_0000, '0);
        send_req(skt_pkg::OP_REMOVE, 32'h7FFF_FFFF, '0);
        send_req(skt_pkg::OP_REMOVE, 32'hFFFF_FFFF, '0);
        send_req(skt_pkg::OP_REMOVE, 32'h0000_0001, '0);
        send_req(skt_pkg::OP_SEARCH, 32'h0000_0001, '0);
    endtask

    task automatic test_fill();
        for (int i = 0; i < CAP; i++)
            send_req(skt_pkg::OP_INSERT, ((i * 37) % CAP) * 1000 - 64000, pick_payload());
        // full check wins over duplicate check
        send_req(skt_pkg::OP_INSERT, 32'h0001_0000, pick_payload());
        send_req(skt_pkg::OP_INSERT, -32'sd64000, pick_payload());
        send_req(skt_pkg::OP_REMOVE, 32'h0000_0007, '0);
        send_req(skt_pkg::OP_SEARCH, 32'sd5000, '0);
        send_req(OP_IGNORED,         32'h7FFF_FFFF, '1);
        send_req(skt_pkg::OP_REMOVE, 32'sd5000, '0);
        send_req(skt_pkg::OP_INSERT, 32'h8000_0000, '1);
        send_req(skt_pkg::OP_INSERT, 32'h7FFF_FFFF, '1);
        send_req(skt_pkg::OP_SEARCH, 32'h8000_0000, '0);
        for (int i = 0; i < CAP; i++)
            send_req(skt_pkg::OP_REMOVE, ((i * 53) % CAP) * 1000 - 64000, pick_payload());
        send_req(skt_pkg::OP_SEARCH, 32'h8000_0000, '0);
        send_req(skt_pkg::OP_REMOVE, 32'h8000_0000, '0);
        send_req(skt_pkg::OP_SEARCH, 32'h8000_0000, '0);
    endtask

    task automatic test_backpressure();
        steady   = 1'b1;
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
            send_req(pick_op(1'b1), pick_key(), pick_payload());
        steady = 1'b0;
    endtask

    task automatic test_random();
        for (int i = 0; i < 280; i++)
            send_req(pick_op(((i / 100) % 2) == 0), pick_key(), pick_payload());
    endtask

    initial
    begin : result_sink
        int seg_left;
        int density;
        int hold_left;
        seg_left  = 0;
        density   = 0;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(1, 40);
                    case ($urandom_range(0, 3))
                        0: density = 0;
                        1: density = 25;
                        2: density = 50;
                        default: density = 85;
                    endcase
                end
                seg_left--;
                out_stall <= ($urandom_range(0, 99) < density);
            end
        end
    end

    initial
    begin : result_check
        reply_t exp_r;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
            begin
                if (reply_q.size() == 0)
                    report_mismatch("result with no request pending");
                else
                begin
                    exp_r = reply_q.pop_front();
                    if (status !== exp_r.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  status, exp_r.status));
                    if (payload_out !== exp_r.payload)
                        report_mismatch($sformatf("payload_out %h, want %h",
                                                  payload_out, exp_r.payload));
                    if (entry_count !== exp_r.count)
                        report_mismatch($sformatf("entry_count %0d, want %0d",
                                                  entry_count, exp_r.count));
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        err_count    = 0;
        shadow_count = 0;
        burst_left   = 0;
        steady       = 1'b0;
        hold_req     = 1'b0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        req_type   <= skt_pkg::OP_INSERT;
        key        <= '0;
        payload_in <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill();
        test_backpressure();
        test_random();
        in_valid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sorted_key_table.f @@
design/skt_pkg.sv
design/skt_cell.sv
design/skt_group.sv
design/sorted_key_table.sv
design/skt_checker.sv
test/tb_top.sv
